// File: hdl/dq_pkg.sv
// Shared constants, codes and types of the double-ended queue.
package dq_pkg;

  localparam int DEPTH     = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IN_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CNT_W + 2 * VAL_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } mem_req_t;

endpackage

// File: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//   channel | direction | tdata (low bit up)                | tuser
//   in_     | slave     | value[31:0]                       | kind[1:0]
//   out_    | master    | count[4:0], front[31:0], rear[31:0] | status[1:0]
//
// Each word passes through three steps: accept, pointer update with memory write and
// two-port read, then result load. The registered entry RAM read sets this.
// rst_n clears pointers, count and the output valid; entries need no clear.
// A stalled result holds in the output register; input waits until it loads.
module double_ended_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dq_pkg::IN_DATA_W-1:0]  in_tdata,   // value
  input  logic [dq_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dq_pkg::OUT_DATA_W-1:0] out_tdata,  // count, front_value, rear_value
  output logic [dq_pkg::STAT_W-1:0]     out_tuser   // status
);
  import dq_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] rd_data_a;
  logic [VAL_W-1:0] rd_data_b;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_req    (mem_req),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b)
  );

  dq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (mem_req.wr_en),
    .wr_addr   (mem_req.wr_addr),
    .wr_data   (mem_req.wr_data),
    .rd_en     (mem_req.rd_en),
    .rd_addr_a (mem_req.rd_addr_a),
    .rd_addr_b (mem_req.rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

// File: hdl/dq_ram.sv
// Generic RAM: one write port, two registered read ports.
module dq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_a,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hdl/dq_ctrl.sv
// Pointer, count and handshake control of the double-ended queue.
module dq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dq_pkg::IN_DATA_W-1:0]  in_tdata,   // value
  input  logic [dq_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dq_pkg::OUT_DATA_W-1:0] out_tdata,  // count, front_value, rear_value
  output logic [dq_pkg::STAT_W-1:0]     out_tuser,  // status
  output dq_pkg::mem_req_t              mem_req,
  input  logic [dq_pkg::VAL_W-1:0]      rd_data_a,
  input  logic [dq_pkg::VAL_W-1:0]      rd_data_b
);
  import dq_pkg::*;

  localparam int SUM_W = CNT_W + 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  function automatic logic [ADDR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return t[ADDR_W-1:0];
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [VAL_W-1:0]  value_r;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              fwd_a_r, fwd_b_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0] out_tuser_r;
  logic              full, empty, load_out;
  logic [ADDR_W-1:0] rear_addr;
  logic [VAL_W-1:0]  fv, rv;

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign full  = (held_r == CNT_W'(DEPTH));
  assign empty = (held_r == '0);
  assign load_out = (state_r == S_RESP) && (!out_tvalid_r || out_tready);

  always_comb begin
    front_nxt  = front_r;
    held_nxt   = held_r;
    status_nxt = ST_DONE;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = wrap(SUM_W'(front_r) + SUM_W'(held_r));
    mem_req.wr_data = value_r;
    unique case (kind_r)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = (front_r == '0) ? ADDR_W'(DEPTH - 1) : front_r - ADDR_W'(1);
          held_nxt  = held_r + CNT_W'(1);
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = front_nxt;
        end
      end
      KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          held_nxt = held_r + CNT_W'(1);
          mem_req.wr_en = 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          front_nxt = wrap(SUM_W'(front_r) + SUM_W'(1));
          held_nxt  = held_r - CNT_W'(1);
        end
      end
      KIND_POP_REAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          held_nxt = held_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
    if (state_r != S_EXEC) begin
      mem_req.wr_en = 1'b0;
    end
    rear_addr = (held_nxt == '0) ? front_nxt
              : wrap(SUM_W'(front_nxt) + SUM_W'(held_nxt) - SUM_W'(1));
    mem_req.rd_en     = (state_r == S_EXEC);
    mem_req.rd_addr_a = front_nxt;
    mem_req.rd_addr_b = rear_addr;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign fv = empty ? '0 : (fwd_a_r ? value_r : rd_data_a);
  assign rv = empty ? '0 : (fwd_b_r ? value_r : rd_data_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      held_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        front_r <= front_nxt;
        held_r  <= held_nxt;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      value_r <= in_tdata[VAL_W-1:0];
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      fwd_a_r  <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr_a);
      fwd_b_r  <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr_b);
    end
    if (load_out) begin
      out_tuser_r <= status_r;
      out_tdata_r <= OUT_DATA_W'({rv, fv, held_r});
    end
  end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the double-ended queue: directed table, then random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int RANDOM_WORDS = 1525;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 300;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  front;
    logic [VAL_W-1:0]  rear;
  } deque_word_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    bit                typed;
    deque_word_t       want;
  } request_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  logic [VAL_W-1:0]  model_slots [DEPTH];
  logic [ADDR_W-1:0] model_front = '0;
  logic [CNT_W-1:0]  model_held = '0;

  deque_word_t  expected_words [$];
  request_row_t request_rows [$];
  int           err_cnt = 0;
  int           accepted_words = 0;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_word_t deque_apply(input logic [KIND_W-1:0] kind,
                                              input logic [VAL_W-1:0] value);
    deque_word_t       res;
    logic [ADDR_W-1:0] slot;
    res.status = ST_DONE;
    res.front  = '0;
    res.rear   = '0;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR) begin
      if (model_held >= DEPTH) begin
        res.status = ST_FULL;
      end else if (kind == KIND_PUSH_FRONT) begin
        model_front = model_front - 1'b1;
        model_slots[model_front] = value;
        model_held = model_held + 1'b1;
      end else begin
        slot = model_front + model_held[ADDR_W-1:0];
        model_slots[slot] = value;
        model_held = model_held + 1'b1;
      end
    end else begin
      if (model_held == 0) begin
        res.status = ST_EMPTY;
      end else if (kind == KIND_POP_FRONT) begin
        model_front = model_front + 1'b1;
        model_held = model_held - 1'b1;
      end else begin
        model_held = model_held - 1'b1;
      end
    end
    if (model_held != 0) begin
      slot = model_front + model_held[ADDR_W-1:0] - 1'b1;
      res.front = model_slots[model_front];
      res.rear  = model_slots[slot];
    end
    res.count = model_held;
    return res;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                         input bit typed, input logic [STAT_W-1:0] status,
                         input int count, input logic [VAL_W-1:0] front,
                         input logic [VAL_W-1:0] rear);
    request_row_t row;
    row.kind        = kind;
    row.value       = value;
    row.typed       = typed;
    row.want.status = status;
    row.want.count  = CNT_W'(count);
    row.want.front  = front;
    row.want.rear   = rear;
    request_rows.push_back(row);
  endtask

  task automatic offer_word(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    accepted_words++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    deque_word_t want;
    deque_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.count  = out_tdata[CNT_W-1:0];
      got.front  = out_tdata[CNT_W +: VAL_W];
      got.rear   = out_tdata[CNT_W + VAL_W +: VAL_W];
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d count %0d", got.status, got.count);
        err_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          err_cnt++;
        end
        if (got.front !== want.front) begin
          $error("front_value: expected %h, got %h", want.front, got.front);
          err_cnt++;
        end
        if (got.rear !== want.rear) begin
          $error("rear_value: expected %h, got %h", want.rear, got.rear);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int  mode;
    int  span;
    bit  held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && accepted_words >= HOLD_AFTER) begin
        held_off = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 80);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 9) == 0);
          default: out_tready <= c[1];
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    request_row_t      row;
    deque_word_t       res;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    int                phase_left;
    int                burst_left;
    int                push_pct;

    for (int i = 0; i < DEPTH; i++) model_slots[i] = '0;

    add_row(KIND_POP_FRONT,  32'h0000_0000, 1, ST_EMPTY, 0, 32'h0, 32'h0);
    add_row(KIND_POP_REAR,   32'hFFFF_FFFF, 1, ST_EMPTY, 0, 32'h0, 32'h0);
    add_row(KIND_PUSH_FRONT, 32'h7FFF_FFFF, 1, ST_DONE,  1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_row(KIND_PUSH_REAR,  32'h8000_0000, 1, ST_DONE,  2, 32'h7FFF_FFFF, 32'h8000_0000);
    add_row(KIND_POP_FRONT,  32'h0000_0000, 1, ST_DONE,  1, 32'h8000_0000, 32'h8000_0000);
    add_row(KIND_POP_REAR,   32'h0000_0000, 1, ST_DONE,  0, 32'h0, 32'h0);
    add_row(KIND_PUSH_REAR,  32'hFFFF_FFFF, 1, ST_DONE,  1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_row(KIND_PUSH_FRONT, 32'h0000_0000, 1, ST_DONE,  2, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH - 2; i++)
      add_row(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, 32'h0101_0101 * (i + 1),
              0, ST_DONE, 0, '0, '0);
    add_row(KIND_PUSH_FRONT, 32'h1234_5678, 0, ST_DONE, 0, '0, '0);
    add_row(KIND_PUSH_REAR,  32'hA5A5_A5A5, 0, ST_DONE, 0, '0, '0);
    add_row(KIND_POP_REAR,   32'h0000_0000, 0, ST_DONE, 0, '0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (request_rows[i]) begin
      row = request_rows[i];
      offer_word(row.kind, row.value);
      res = deque_apply(row.kind, row.value);
      expected_words.push_back(row.typed ? row.want : res);
    end

    phase_left = 0;
    burst_left = 0;
    push_pct   = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      phase_left--;
      if (n == RANDOM_WORDS / 2) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if ($urandom_range(0, 99) < push_pct)
        kind = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
      else
        kind = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
      case ($urandom_range(0, 7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        default: value = $urandom;
      endcase
      offer_word(kind, value);
      expected_words.push_back(deque_apply(kind, value));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
